[hdl/longest_window_within_band_macros.svh]
// Assertion macros for the longest_window_within_band checker.
// No dependencies; included by the checker file by bare name.
`ifndef LONGEST_WINDOW_WITHIN_BAND_MACROS_SVH
`define LONGEST_WINDOW_WITHIN_BAND_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define LWB_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lwb check failed");

// Next-cycle implication, disabled while reset is high
`define LWB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lwb check failed");

`endif

[hdl/lwb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the longest-window-within-band block.
// No dependencies; imported by the cells, the queue, the top level and the checker.
package lwb_pkg;

  // configuration register
  localparam int   BAND_BITS      = 4;
  localparam int   APB_DATA_BITS  = 32;
  localparam int   APB_ADDR_BITS  = 3;
  localparam logic REG_BAND_WIDTH = 1'b0;   // register index, taken from paddr[2]
  localparam logic [BAND_BITS-1:0] BAND_RESET = 4'd1;

  // cell row operations
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_AGE   = 3'd1;
  localparam logic [2:0] OP_SHIFT = 3'd2;
  localparam logic [2:0] OP_PUSH  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       max_mode;   // 1: decreasing (max) queue, 0: increasing (min) queue
  } lwb_ctrl_t;

  typedef struct packed {
    logic front_valid;
    logic full;             // every cell survives the pop pass
  } lwb_qstat_t;

endpackage

[hdl/lwb_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and results out.
// No dependencies.
interface lwb_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface lwb_result_if #(parameter int LENGTH_BITS = 24);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] run_length;
  logic [LENGTH_BITS-1:0] best_length;
  logic                   is_final;

  modport source (output valid, output run_length, output best_length, output is_final,
                  input ready);
  modport sink   (input valid, input run_length, input best_length, input is_final,
                  output ready);
endinterface

[hdl/lwb_cell.sv]
`timescale 1ns / 1ps
// One queue cell: holds a value, its age and an occupied flag.
// Depends on lwb_pkg; instantiated in a row by lwb_queue.
module lwb_cell
  import lwb_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lwb_ctrl_t              ctrl,
  input  logic [SAMPLE_BITS-1:0] new_val,
  input  logic [SAMPLE_BITS-1:0] nb_val,
  input  logic [LENGTH_BITS-1:0] nb_age,
  input  logic                   nb_valid,
  input  logic                   prev_kept,
  input  logic                   full,
  output logic [SAMPLE_BITS-1:0] val,
  output logic [LENGTH_BITS-1:0] age,
  output logic                   valid,
  output logic                   kept
);

  // survives the back pop when the new sample arrives
  assign kept = valid && (ctrl.max_mode ? (val > new_val) : (val < new_val));

  // occupied flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_SHIFT: valid <= nb_valid;
        OP_PUSH: begin
          if (full) begin
            valid <= nb_valid;
          end else begin
            valid <= kept || prev_kept;
          end
        end
        OP_CLEAR: valid <= 1'b0;
        default:  valid <= valid;
      endcase
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_AGE: begin
        if (age != {LENGTH_BITS{1'b1}}) begin
          age <= age + 1'b1;
        end
      end
      OP_SHIFT: begin
        val <= nb_val;
        age <= nb_age;
      end
      OP_PUSH: begin
        if (full) begin
          val <= nb_val;
          age <= nb_age;
        end else if (prev_kept && !kept) begin
          val <= new_val;
          age <= '0;
        end
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule

[hdl/lwb_queue.sv]
`timescale 1ns / 1ps
// Monotonic queue as a row of cells; the front is cell 0, data moves toward it.
// Depends on lwb_pkg and lwb_cell.
module lwb_queue
  import lwb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lwb_ctrl_t              ctrl,
  input  logic [SAMPLE_BITS-1:0] new_val,
  output logic [SAMPLE_BITS-1:0] front_val,
  output logic [LENGTH_BITS-1:0] front_age,
  output lwb_qstat_t             stat
);

  logic [SAMPLE_BITS-1:0] val_q  [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0] age_q  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [QUEUE_DEPTH-1:0] kept_q;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] nb_val;
      logic [LENGTH_BITS-1:0] nb_age;
      logic                   nb_valid;
      logic                   prev_kept;

      // the tail cell's neighbour is the incoming entry during a push
      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign nb_val   = new_val;
        assign nb_age   = '0;
        assign nb_valid = (ctrl.op == OP_PUSH);
      end else begin : g_body
        assign nb_val   = val_q[i+1];
        assign nb_age   = age_q[i+1];
        assign nb_valid = valid_q[i+1];
      end

      if (i == 0) begin : g_head
        assign prev_kept = 1'b1;
      end else begin : g_link
        assign prev_kept = kept_q[i-1];
      end

      lwb_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_val   (new_val),
        .nb_val    (nb_val),
        .nb_age    (nb_age),
        .nb_valid  (nb_valid),
        .prev_kept (prev_kept),
        .full      (stat.full),
        .val       (val_q[i]),
        .age       (age_q[i]),
        .valid     (valid_q[i]),
        .kept      (kept_q[i])
      );
    end
  endgenerate

  assign front_val        = val_q[0];
  assign front_age        = age_q[0];
  assign stat.front_valid = valid_q[0];
  assign stat.full        = kept_q[QUEUE_DEPTH-1];

endmodule

[hdl/longest_window_within_band.sv]
`timescale 1ns / 1ps
// Longest in-band window: one sample in, one result out, one item at a time.
// An item passes from acceptance through the band drop, staleness drop and push states
// in that order, with one drop per queue per cycle in each drop state; the push waits on an
// earlier result the sink has not taken. The result is registered when the push goes
// ahead and may wait for the sink while the next sample is taken. Synchronous
// reset empties both queues, clears the run and best lengths and sets band_width to 1.
module longest_window_within_band
  import lwb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int LENGTH_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  lwb_sample_if.sink               samples,
  lwb_result_if.source             results,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int SUM_BITS = ((SAMPLE_BITS > BAND_BITS) ? SAMPLE_BITS : BAND_BITS) + 1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BAND  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]             state, state_next;
  logic [BAND_BITS-1:0]   band_width;
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic                   cur_last;
  logic [LENGTH_BITS-1:0] run_len, run_len_next;
  logic [LENGTH_BITS-1:0] best_len, best_len_next;
  logic                   res_valid;
  logic [LENGTH_BITS-1:0] res_run, res_best;
  logic                   res_final;

  lwb_ctrl_t              max_ctrl, min_ctrl;
  lwb_qstat_t             max_stat, min_stat;
  logic [SAMPLE_BITS-1:0] max_front_val, min_front_val;
  logic [LENGTH_BITS-1:0] max_front_age, min_front_age;

  logic                   in_beat, out_free, push_go;
  logic [SUM_BITS-1:0]    band_hi, band_lo_hi;
  logic                   max_out_band, min_out_band, max_stale, min_stale;
  logic                   take_max, take_min;
  logic [LENGTH_BITS-1:0] shrink_a, shrink_b;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BAND_WIDTH) ? APB_DATA_BITS'(band_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_width <= BAND_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BAND_WIDTH)) begin
      band_width <= pwdata[BAND_BITS-1:0];
    end
  end

  // handshakes
  assign samples.ready = (state == ST_IDLE);
  assign in_beat       = samples.valid && samples.ready;
  assign out_free      = !res_valid || results.ready;
  assign push_go       = (state == ST_PUSH) && out_free;

  // front checks against the band and the current window
  assign band_hi      = SUM_BITS'(cur_sample) + SUM_BITS'(band_width);
  assign band_lo_hi   = SUM_BITS'(min_front_val) + SUM_BITS'(band_width);
  assign max_out_band = max_stat.front_valid && (SUM_BITS'(max_front_val) > band_hi);
  assign min_out_band = min_stat.front_valid && (SUM_BITS'(cur_sample) > band_lo_hi);
  assign max_stale    = max_stat.front_valid && (run_len != LEN_MAX) &&
                        (max_front_age >= run_len);
  assign min_stale    = min_stat.front_valid && (run_len != LEN_MAX) &&
                        (min_front_age >= run_len);

  // window shrinks to the age of any entry leaving through the front
  always_comb begin
    take_max = 1'b0;
    take_min = 1'b0;
    if (state == ST_BAND) begin
      take_max = max_out_band;
      take_min = min_out_band;
    end else if (state == ST_PUSH) begin
      take_max = max_stat.full;
      take_min = min_stat.full;
    end
    shrink_a = run_len;
    if (take_max && (max_front_age < shrink_a)) begin
      shrink_a = max_front_age;
    end
    shrink_b = shrink_a;
    if (take_min && (min_front_age < shrink_b)) begin
      shrink_b = min_front_age;
    end
  end

  // sequencer and queue commands
  always_comb begin
    state_next        = state;
    run_len_next      = run_len;
    best_len_next     = best_len;
    max_ctrl.op       = OP_HOLD;
    max_ctrl.max_mode = 1'b1;
    min_ctrl.op       = OP_HOLD;
    min_ctrl.max_mode = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          max_ctrl.op  = OP_AGE;
          min_ctrl.op  = OP_AGE;
          run_len_next = (run_len == LEN_MAX) ? run_len : run_len + 1'b1;
          state_next   = ST_BAND;
        end
      end
      ST_BAND: begin
        run_len_next = shrink_b;
        if (max_out_band) begin
          max_ctrl.op = OP_SHIFT;
        end
        if (min_out_band) begin
          min_ctrl.op = OP_SHIFT;
        end
        if (!max_out_band && !min_out_band) begin
          state_next = ST_STALE;
        end
      end
      ST_STALE: begin
        if (max_stale) begin
          max_ctrl.op = OP_SHIFT;
        end
        if (min_stale) begin
          min_ctrl.op = OP_SHIFT;
        end
        if (!max_stale && !min_stale) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (cur_last) begin
            max_ctrl.op   = OP_CLEAR;
            min_ctrl.op   = OP_CLEAR;
            run_len_next  = '0;
            best_len_next = '0;
          end else begin
            max_ctrl.op   = OP_PUSH;
            min_ctrl.op   = OP_PUSH;
            run_len_next  = shrink_b;
            best_len_next = (shrink_b > best_len) ? shrink_b : best_len;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run_len   <= '0;
      best_len  <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      run_len  <= run_len_next;
      best_len <= best_len_next;
      if (push_go) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // sample and result payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_sample <= samples.sample;
      cur_last   <= samples.last_sample;
    end
    if (push_go) begin
      res_run   <= shrink_b;
      res_best  <= (shrink_b > best_len) ? shrink_b : best_len;
      res_final <= cur_last;
    end
  end

  assign results.valid       = res_valid;
  assign results.run_length  = res_run;
  assign results.best_length = res_best;
  assign results.is_final    = res_final;

  // monotonic queues
  lwb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_max_q (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (max_ctrl),
    .new_val   (cur_sample),
    .front_val (max_front_val),
    .front_age (max_front_age),
    .stat      (max_stat)
  );

  lwb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_min_q (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (min_ctrl),
    .new_val   (cur_sample),
    .front_val (min_front_val),
    .front_age (min_front_age),
    .stat      (min_stat)
  );

endmodule

[hdl/lwb_check.sv]
`timescale 1ns / 1ps
// Port-level checker for longest_window_within_band, attached by bind.
// Depends on lwb_pkg and longest_window_within_band_macros.svh.
`include "longest_window_within_band_macros.svh"

module lwb_check
  import lwb_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [LENGTH_BITS-1:0]   run_length,
  input logic [LENGTH_BITS-1:0]   best_length,
  input logic                     is_final,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic                     pready,
  input logic [APB_ADDR_BITS-1:0] paddr,
  input logic [APB_DATA_BITS-1:0] pwdata,
  input logic [APB_DATA_BITS-1:0] prdata
);

  // a stalled result beat holds
  `LWB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(run_length) && $stable(best_length) && $stable(is_final))

  // a run is never empty and never longer than the best so far
  `LWB_ASSERT_NOW(a_run_le_best, clk, rst, out_valid, (run_length != '0) && (run_length <= best_length))

  // one item at a time: no sample beat right after another
  `LWB_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // a written band width reads back
  `LWB_ASSERT_NEXT(a_band_readback, clk, rst, psel && penable && pwrite && pready && (paddr[2] == REG_BAND_WIDTH), (paddr[2] != REG_BAND_WIDTH) || (prdata[BAND_BITS-1:0] == $past(pwdata[BAND_BITS-1:0])))

endmodule

bind longest_window_within_band lwb_check #(
  .LENGTH_BITS (LENGTH_BITS)
) u_lwb_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .run_length  (results.run_length),
  .best_length (results.best_length),
  .is_final    (results.is_final),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

[dv/longest_window_within_band_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for longest_window_within_band: directed and random sample streams
// against an in-bench window predictor. Needs lwb_pkg, lwb_ifs and the block itself.
module longest_window_within_band_tb;
  import lwb_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int LENGTH_W = 24;
  localparam int DEPTH    = 16;
  localparam logic [LENGTH_W-1:0]      LEN_LIMIT  = {LENGTH_W{1'b1}};
  localparam logic [APB_ADDR_BITS-1:0] BAND_ADDR  = {REG_BAND_WIDTH, 2'b00};
  localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = {~REG_BAND_WIDTH, 2'b00};
  localparam logic [SAMPLE_W-1:0]      TOP        = {SAMPLE_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [LENGTH_W-1:0] age;
  } band_entry_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] run_length;
    logic [LENGTH_W-1:0] best_length;
    logic                is_final;
  } window_result_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  lwb_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
  lwb_result_if #(.LENGTH_BITS(LENGTH_W)) result_ch ();

  longest_window_within_band #(
    .QUEUE_DEPTH(DEPTH),
    .SAMPLE_BITS(SAMPLE_W),
    .LENGTH_BITS(LENGTH_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .samples(sample_ch.sink),
    .results(result_ch.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state: band register, both monotonic queues, run and best lengths
  logic [BAND_BITS-1:0] band_now;
  band_entry_t          peak_q[$];    // strictly decreasing values
  band_entry_t          floor_q[$];   // strictly increasing values
  logic [LENGTH_W-1:0]  run_len;
  logic [LENGTH_W-1:0]  seen_count;
  logic [LENGTH_W-1:0]  best_len;

  window_result_t expected_windows[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [LENGTH_W-1:0] sat_step(input logic [LENGTH_W-1:0] x);
    return (x == LEN_LIMIT) ? x : x + 1'b1;
  endfunction

  function automatic void shorten_run(input logic [LENGTH_W-1:0] age);
    if (age < run_len) run_len = age;
  endfunction

  function automatic void clear_windows();
    peak_q.delete();
    floor_q.delete();
    run_len    = '0;
    seen_count = '0;
    best_len   = '0;
  endfunction

  // one sample through the predictor; returns the beat the block should emit
  function automatic window_result_t predict_window(input logic [SAMPLE_W-1:0] v,
                                                    input logic fin);
    window_result_t r;
    int vi;
    int bw;
    vi = int'(v);
    bw = int'(band_now);
    seen_count = sat_step(seen_count);
    run_len    = sat_step(run_len);
    foreach (peak_q[i]) peak_q[i].age = sat_step(peak_q[i].age);
    foreach (floor_q[i]) floor_q[i].age = sat_step(floor_q[i].age);

    // older samples outside the band around v end the window
    while (peak_q.size() > 0 && int'(peak_q[0].value) > vi + bw) begin
      shorten_run(peak_q[0].age);
      void'(peak_q.pop_front());
    end
    while (floor_q.size() > 0 && vi > int'(floor_q[0].value) + bw) begin
      shorten_run(floor_q[0].age);
      void'(floor_q.pop_front());
    end

    // entries that fell out of the window
    while (peak_q.size() > 0 && run_len < LEN_LIMIT && peak_q[0].age >= run_len)
      void'(peak_q.pop_front());
    while (floor_q.size() > 0 && run_len < LEN_LIMIT && floor_q[0].age >= run_len)
      void'(floor_q.pop_front());

    // push, keeping each queue monotonic; a full queue loses its oldest entry
    while (peak_q.size() > 0 && peak_q[$].value <= v) void'(peak_q.pop_back());
    if (peak_q.size() >= DEPTH) begin
      shorten_run(peak_q[0].age);
      void'(peak_q.pop_front());
    end
    peak_q.insert(peak_q.size(), band_entry_t'{value: v, age: '0});
    while (floor_q.size() > 0 && floor_q[$].value >= v) void'(floor_q.pop_back());
    if (floor_q.size() >= DEPTH) begin
      shorten_run(floor_q[0].age);
      void'(floor_q.pop_front());
    end
    floor_q.insert(floor_q.size(), band_entry_t'{value: v, age: '0});

    if (run_len > best_len) best_len = run_len;
    r.run_length  = run_len;
    r.best_length = best_len;
    r.is_final    = fin;
    if (fin) clear_windows();
    return r;
  endfunction

  // result sink stalls
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin
    window_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_windows.size() == 0) begin
        $error("result beat with nothing expected: run_length %0d best_length %0d",
               result_ch.run_length, result_ch.best_length);
        mismatches++;
      end else begin
        want = expected_windows.pop_front();
        if (result_ch.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, result_ch.run_length);
          mismatches++;
        end
        if (result_ch.best_length !== want.best_length) begin
          $error("best_length: expected %0d, got %0d", want.best_length,
                 result_ch.best_length);
          mismatches++;
        end
        if (result_ch.is_final !== want.is_final) begin
          $error("is_final: expected %0d, got %0d", want.is_final, result_ch.is_final);
          mismatches++;
        end
      end
    end
  end

  // one sample beat, with an optional idle gap in front; valid stays high afterwards
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic fin);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.sample      <= s;
    sample_ch.last_sample <= fin;
    do @(posedge clk); while (!sample_ch.ready);
    expected_windows.insert(expected_windows.size(), predict_window(s, fin));
  endtask

  // stop sending and let every expected beat come out
  task automatic quiesce();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_windows.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_BAND_WIDTH) band_now = data[BAND_BITS-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read the band register back and compare with the predictor's copy
  task automatic band_readback();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= BAND_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[BAND_BITS-1:0] !== band_now) begin
      $error("band_width: expected %0d, got %0d", band_now, prdata[BAND_BITS-1:0]);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reset value of the band, small steps around it, full-scale samples
  task automatic test_reset_band();
    band_readback();
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd2, 1'b1);
    send_sample(TOP, 1'b0);
    send_sample(TOP - 16'd1, 1'b0);
    send_sample(TOP, 1'b1);
    quiesce();
  endtask

  // zero and full band, ignored upper data bits, spare register address
  task automatic test_band_extremes();
    reg_write(BAND_ADDR, 32'h0);
    band_readback();
    send_sample(16'd5, 1'b0);
    send_sample(16'd5, 1'b0);
    send_sample(16'd6, 1'b0);
    send_sample(16'd6, 1'b1);
    quiesce();
    reg_write(BAND_ADDR, 32'hFFFF_FFFF);
    reg_write(SPARE_ADDR, 32'h0000_0003);
    band_readback();
    send_sample(16'd0, 1'b0);
    send_sample(16'd15, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd16, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(TOP, 1'b0);
    send_sample(TOP - 16'd15, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h5555, 1'b1);
    quiesce();
    reg_write(BAND_ADDR, 32'h1234_5677);
    band_readback();
  endtask

  // random sequences: mostly band-hugging walks, some noise, some unterminated
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int items);
    int sent;
    int seq_len;
    int mode;
    int val;
    int spread;
    int k;
    int dir;
    logic [BAND_BITS-1:0] nb;
    logic [APB_DATA_BITS-1:0] word;
    logic fin;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < items) begin
      // occasional band change, only with the block drained
      if ($urandom_range(0, 5) == 0) begin
        quiesce();
        case ($urandom_range(0, 3))
          0:       nb = '0;
          1:       nb = '1;
          default: nb = BAND_BITS'($urandom_range(0, 15));
        endcase
        word = $urandom();
        word[BAND_BITS-1:0] = nb;
        reg_write(BAND_ADDR, word);
        if ($urandom_range(0, 3) == 0) band_readback();
      end
      seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      mode    = $urandom_range(0, 9);
      spread  = int'(band_now) + 2;
      dir     = $urandom_range(0, 1) ? 1 : -1;
      case (mode)
        8:       val = $urandom_range(0, 1) ? 65535 : 0;
        default: val = $urandom_range(0, 65535);
      endcase
      for (k = 0; k < seq_len; k++) begin
        case (mode)
          7: val = $urandom_range(0, 65535);
          9: val = val + (($urandom_range(0, 3) == 0) ? dir : 0);
          default: begin
            if ($urandom_range(0, 24) == 0) val = $urandom_range(0, 65535);
            else val = val + $urandom_range(0, 2 * spread) - spread;
          end
        endcase
        if (val < 0) val = 0;
        if (val > 65535) val = 65535;
        // most sequences close with a final sample, a few run on into the next
        fin = (k == seq_len - 1) && ($urandom_range(0, 7) != 0);
        send_sample(val[SAMPLE_W-1:0], fin);
        sent++;
      end
    end
    quiesce();
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.sample      = '0;
    sample_ch.last_sample = 1'b0;
    mismatches            = 0;
    send_idle_pct         = 19;
    recv_idle_pct         = 46;
    band_now              = BAND_RESET;
    clear_windows();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_reset_band();
    test_band_extremes();
    test_random_traffic(19, 46, 670);
    test_random_traffic(46, 19, 670);
    test_random_traffic(0, 0, 670);

    if (expected_windows.size() > 0) begin
      $error("%0d expected result beats never arrived", expected_windows.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
